[rtl/core/epw_pkg.sv]
// ----------------------------------------------------------------------------
// epw_pkg
// Shared constants, types and helper functions of the euler path walker.
// ----------------------------------------------------------------------------
`default_nettype none

package epw_pkg;

  localparam int unsigned VCNT   = 8;
  localparam int unsigned VW     = $clog2(VCNT);
  localparam int unsigned MAX_E  = VCNT * (VCNT + 1) / 2;
  localparam int unsigned EW     = $clog2(MAX_E + 1);

  typedef logic [VCNT-1:0] row_t;
  typedef logic [VW-1:0]   vtx_t;
  typedef logic [VW:0]     cnt_t;
  typedef logic [EW-1:0]   ecnt_t;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_RUN    = 1'b1;

  localparam logic [1:0] ST_EDGE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_STUCK  = 2'd2;

  // control of the two row memories
  typedef struct packed {
    logic  ld_we;
    vtx_t  ld_waddr;
    row_t  ld_wdata;
    vtx_t  ld_raddr;
    logic  wk_we;
    vtx_t  wk_waddr;
    row_t  wk_wdata;
    vtx_t  wk_raddr;
  } mem_ctrl_t;

  function automatic cnt_t popcount(input row_t r);
    cnt_t c;
    c = '0;
    for (int i = 0; i < VCNT; i++) begin
      c = c + cnt_t'(r[i]);
    end
    return c;
  endfunction

  // index of the lowest set bit, zero when none
  function automatic vtx_t lowest(input row_t r);
    vtx_t v;
    logic hit;
    v   = '0;
    hit = 1'b0;
    for (int i = 0; i < VCNT; i++) begin
      if (r[i] && !hit) begin
        v   = vtx_t'(i);
        hit = 1'b1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/epw_row_store.sv]
// ----------------------------------------------------------------------------
// epw_row_store
// Loaded and working adjacency rows, one write and one registered read port
// each; loaded rows carry valid bits so they read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module epw_row_store (
  input  wire                 clk,
  input  wire                 rst_n,
  input  epw_pkg::mem_ctrl_t  ctrl,
  output epw_pkg::row_t       ld_rdata,
  output epw_pkg::row_t       wk_rdata
);

  epw_pkg::row_t ld_mem [epw_pkg::VCNT];
  epw_pkg::row_t wk_mem [epw_pkg::VCNT];
  epw_pkg::row_t ld_q_r;
  epw_pkg::row_t wk_q_r;
  epw_pkg::row_t ld_vld_r;
  logic          ld_qv_r;

  always_ff @(posedge clk) begin
    if (ctrl.ld_we) begin
      ld_mem[ctrl.ld_waddr] <= ctrl.ld_wdata;
    end
    ld_q_r <= ld_mem[ctrl.ld_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wk_we) begin
      wk_mem[ctrl.wk_waddr] <= ctrl.wk_wdata;
    end
    wk_q_r <= wk_mem[ctrl.wk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= '0;
      ld_qv_r  <= 1'b0;
    end else begin
      if (ctrl.ld_we) begin
        ld_vld_r[ctrl.ld_waddr] <= 1'b1;
      end
      ld_qv_r <= ld_vld_r[ctrl.ld_raddr];
    end
  end

  assign ld_rdata = ld_qv_r ? ld_q_r : '0;
  assign wk_rdata = wk_q_r;

endmodule

`default_nettype wire

[rtl/core/euler_path_walker_top.sv]
// Load transaction: taken while idle, no result.
// Run transaction: copy of the loaded rows into the working rows, then
// per edge a row read, a scan of up to 8 neighbour rows through the
// single working-row read port, one or two write-backs and a result.
// Reset clears control state; loaded rows read as zero until written.
// ----------------------------------------------------------------------------
// euler_path_walker_top
// Fleury-style euler path walk over an 8-vertex adjacency matrix held in
// synchronous row memories, with a degree heuristic as bridge test.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_path_walker_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_opcode,
  input  wire  [2:0] in_row_index,
  input  wire  [7:0] in_row_bits,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_from_vertex,
  output logic [2:0] out_to_vertex,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_RDU  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_WRU  = 3'd4;
  localparam logic [2:0] S_WRP  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  epw_pkg::cnt_t       cnt_r, cnt_nxt;
  epw_pkg::vtx_t       cur_r, cur_nxt;
  epw_pkg::ecnt_t      edges_r, edges_nxt;
  epw_pkg::vtx_t       start_r, start_nxt;
  logic                found_r, found_nxt;
  epw_pkg::row_t       rowu_r, rowu_nxt;
  epw_pkg::vtx_t       pick_r, pick_nxt;
  epw_pkg::vtx_t       res_from_r, res_from_nxt;
  epw_pkg::vtx_t       res_to_r, res_to_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                res_last_r, res_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_from_r, out_from_nxt;
  logic [2:0]          out_to_r, out_to_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  epw_pkg::mem_ctrl_t  mc;
  epw_pkg::row_t       ld_rdata;
  epw_pkg::row_t       wk_rdata;
  epw_pkg::vtx_t       j;
  logic                slot_free;
  logic                emit_fire;

  epw_row_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mc),
    .ld_rdata (ld_rdata),
    .wk_rdata (wk_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_fire = (state_r == S_EMIT) && slot_free;
  // row index whose data is on the read port during copy and scan
  assign j = epw_pkg::vtx_t'(cnt_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    edges_nxt      = edges_r;
    start_nxt      = start_r;
    found_nxt      = found_r;
    rowu_nxt       = rowu_r;
    pick_nxt       = pick_r;
    res_from_nxt   = res_from_r;
    res_to_nxt     = res_to_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_from_nxt   = out_from_r;
    out_to_nxt     = out_to_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    mc          = '0;
    mc.ld_waddr = epw_pkg::vtx_t'(in_row_index);
    mc.ld_wdata = epw_pkg::row_t'(in_row_bits);
    mc.ld_raddr = cnt_r[epw_pkg::VW-1:0];
    mc.wk_raddr = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == epw_pkg::OP_RUN) begin
            cnt_nxt   = '0;
            edges_nxt = '0;
            found_nxt = 1'b0;
            start_nxt = '0;
            state_nxt = S_COPY;
          end else if (32'(in_row_index) < epw_pkg::VCNT) begin
            mc.ld_we = 1'b1;
          end
        end
      end

      S_COPY: begin
        if (cnt_r != '0) begin
          mc.wk_we    = 1'b1;
          mc.wk_waddr = j;
          mc.wk_wdata = ld_rdata;
          // upper triangle, diagonal included
          edges_nxt = edges_r + epw_pkg::ecnt_t'(epw_pkg::popcount(
                        ld_rdata & ~((epw_pkg::row_t'(1) << j) - epw_pkg::row_t'(1))));
          // odd degree is the parity of the row
          if (!found_r && (^ld_rdata)) begin
            found_nxt = 1'b1;
            start_nxt = j;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == epw_pkg::cnt_t'(epw_pkg::VCNT)) begin
          if (edges_nxt == '0) begin
            res_from_nxt   = '0;
            res_to_nxt     = '0;
            res_status_nxt = epw_pkg::ST_EMPTY;
            res_last_nxt   = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            cur_nxt   = start_nxt;
            state_nxt = S_RDU;
          end
        end
      end

      S_RDU: begin
        mc.wk_raddr = cur_r;
        cnt_nxt     = '0;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        mc.wk_raddr = cnt_r[epw_pkg::VW-1:0];
        if (cnt_r == '0) begin
          rowu_nxt = wk_rdata;
          if (wk_rdata == '0) begin
            res_from_nxt   = cur_r;
            res_to_nxt     = '0;
            res_status_nxt = epw_pkg::ST_STUCK;
            res_last_nxt   = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (rowu_r[j] &&
                     (epw_pkg::popcount(wk_rdata) > epw_pkg::cnt_t'(1) ||
                      edges_r == epw_pkg::ecnt_t'(1))) begin
          pick_nxt  = j;
          state_nxt = S_WRU;
        end else if (cnt_r == epw_pkg::cnt_t'(epw_pkg::VCNT)) begin
          // no neighbour passed the degree test
          pick_nxt  = epw_pkg::lowest(rowu_r);
          state_nxt = S_WRU;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_WRU: begin
        mc.wk_we       = 1'b1;
        mc.wk_waddr    = cur_r;
        mc.wk_wdata    = rowu_r & ~(epw_pkg::row_t'(1) << pick_r);
        mc.wk_raddr    = pick_r;
        res_from_nxt   = cur_r;
        res_to_nxt     = pick_r;
        res_status_nxt = epw_pkg::ST_EDGE;
        res_last_nxt   = (edges_r == epw_pkg::ecnt_t'(1));
        // self loop: one entry, already cleared
        state_nxt      = (pick_r == cur_r) ? S_EMIT : S_WRP;
      end

      S_WRP: begin
        mc.wk_we    = 1'b1;
        mc.wk_waddr = pick_r;
        mc.wk_wdata = wk_rdata & ~(epw_pkg::row_t'(1) << cur_r);
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_from_nxt   = 3'(res_from_r);
          out_to_nxt     = 3'(res_to_r);
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          if (res_status_r == epw_pkg::ST_EDGE) begin
            edges_nxt = edges_r - 1'b1;
            cur_nxt   = pick_r;
          end
          state_nxt = res_last_r ? S_IDLE : S_RDU;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      edges_r     <= '0;
      start_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      edges_r     <= edges_nxt;
      start_r     <= start_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rowu_r       <= rowu_nxt;
    pick_r       <= pick_nxt;
    res_from_r   <= res_from_nxt;
    res_to_r     <= res_to_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    out_from_r   <= out_from_nxt;
    out_to_r     <= out_to_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_from_vertex = out_from_r;
  assign out_to_vertex   = out_to_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> edges_r <= epw_pkg::ecnt_t'(epw_pkg::MAX_E))
    else $error("edge count beyond triangle size");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != epw_pkg::ST_EDGE |-> out_last_r)
    else $error("status transaction not marked last");

  a_pick_is_nbr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRU |-> rowu_r[pick_r])
    else $error("picked vertex is not a neighbour");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && res_last_r |=> state_r == S_IDLE)
    else $error("walk continues after final transaction");

  a_last_edge_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && res_status_r == epw_pkg::ST_EDGE && res_last_r |=> edges_r == '0)
    else $error("edges left after final edge");

endmodule

`default_nettype wire
